// ===== rtl/direct_mapped_search_cache_core_assert.svh =====
// Assertion macros shared by the cache RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef DIRECT_MAPPED_SEARCH_CACHE_CORE_ASSERT_SVH
`define DIRECT_MAPPED_SEARCH_CACHE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMSC_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMSC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dmsc_pkg.sv =====
package dmsc_pkg;

  localparam int DMSC_INDEX_BITS = 16;
  localparam int CFG_WIDTH = 5;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 5'd16;

  localparam logic [7:0] AGE_LIMIT = 8'd255;
  localparam logic [7:0] AGE_LAST = AGE_LIMIT - 8'd1;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_STORE = 2'd1;
  localparam logic [1:0] MODE_AGE = 2'd2;

  localparam logic [1:0] KIND_PV = 2'd0;

  typedef struct packed {
    logic [31:0]        tag;
    logic [31:0]        move;
    logic signed [15:0] old_score;
    logic signed [15:0] eval;
    logic signed [15:0] score;
    logic [7:0]         age;
    logic [6:0]         depth;
    logic [1:0]         kind;
  } entry_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        tag;
    logic signed [15:0] score;
    logic [31:0]        move;
    logic [1:0]         kind;
    logic [6:0]         depth;
    logic signed [15:0] eval;
    logic signed [15:0] old_score;
  } req_t;

endpackage

// ===== rtl/direct_mapped_search_cache_core.sv =====
// Direct-mapped search result cache with depth and age replacement.
// Input channel (in_valid/in_ready) carries one request: a lookup, a store or
// an age step. Output channel (out_valid/out_ready) returns exactly one result
// per request: the written flag and the contents of the indexed entry after
// the operation.
// For each request the entry is read from the table memory at the transfer
// edge; the update is computed in the read state and written back, together
// with the result into the output register, at the edge that ends that state.
// A new request is taken only once the previous one has been written back.
// The output register decouples the two sides: a new request is taken while
// the previous result still waits. If the receiver stalls, the next request
// is held after its read until the output register frees up.
// cfg_wr_en writes the number of index bits in use; values above INDEX_BITS
// act as INDEX_BITS.
// After reset the table is cleared one entry per cycle, over all
// 2^INDEX_BITS entries; in_ready stays low during that pass.
module direct_mapped_search_cache_core #(
  parameter int INDEX_BITS = dmsc_pkg::DMSC_INDEX_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dmsc_pkg::CFG_WIDTH-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [63:0]                   position_hash,
  input  logic signed [15:0]            new_score,
  input  logic [31:0]                   new_move,
  input  logic [1:0]                    new_kind,
  input  logic [6:0]                    new_depth,
  input  logic signed [15:0]            new_eval,
  input  logic signed [15:0]            new_old_score,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          written,
  output logic [31:0]                   found_tag,
  output logic signed [15:0]            found_score,
  output logic [31:0]                   found_move,
  output logic [1:0]                    found_kind,
  output logic [6:0]                    found_depth,
  output logic signed [15:0]            found_eval,
  output logic signed [15:0]            found_old_score,
  output logic [7:0]                    found_age
);
  import dmsc_pkg::*;

  `include "direct_mapped_search_cache_core_assert.svh"

  localparam int DEPTH = 2 ** INDEX_BITS;
  localparam int ENTRY_W = $bits(entry_t);
  localparam logic [CFG_WIDTH-1:0] INDEX_BITS_CFG = CFG_WIDTH'(INDEX_BITS);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [INDEX_BITS-1:0] clr_addr;
  logic [CFG_WIDTH-1:0]  index_bits_in_use;
  logic [7:0]            search_age;
  logic [INDEX_BITS-1:0] idx;
  req_t                  req;
  entry_t                out_entry;

  logic [CFG_WIDTH-1:0]  bits_eff;
  logic [INDEX_BITS-1:0] mask;
  logic [INDEX_BITS-1:0] in_idx;
  logic                  in_xfer;
  logic                  fire;

  logic                  ram_wr_en;
  logic [INDEX_BITS-1:0] ram_wr_addr;
  logic [ENTRY_W-1:0]    ram_wr_data;
  logic [INDEX_BITS-1:0] ram_rd_addr;
  logic [ENTRY_W-1:0]    ram_rd_data;

  entry_t                stored;
  entry_t                upd_entry;
  logic                  upd_written;
  logic [7:0]            upd_age;

  assign bits_eff = (index_bits_in_use > INDEX_BITS_CFG) ? INDEX_BITS_CFG
                                                         : index_bits_in_use;

  always_comb begin
    for (int i = 0; i < INDEX_BITS; i++) begin
      mask[i] = (CFG_WIDTH'(i) < bits_eff);
    end
  end

  assign in_idx   = position_hash[INDEX_BITS-1:0] & mask;
  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  // The update runs only when the output register can take its result.
  assign fire     = (state == ST_READ) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == {INDEX_BITS{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      clr_addr          <= '0;
      index_bits_in_use <= CFG_RESET;
      search_age        <= 8'd0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_wr_en) begin
        index_bits_in_use <= cfg_wr_data;
      end
      if (fire) begin
        search_age <= upd_age;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx           <= in_idx;
      req.mode      <= mode;
      req.tag       <= position_hash[63:32];
      req.score     <= new_score;
      req.move      <= new_move;
      req.kind      <= new_kind;
      req.depth     <= new_depth;
      req.eval      <= new_eval;
      req.old_score <= new_old_score;
    end
    if (fire) begin
      out_entry <= upd_entry;
      written   <= upd_written;
    end
  end

  // The read address is held while a request waits so the read data stays put.
  assign ram_rd_addr = (state == ST_IDLE) ? in_idx : idx;
  assign ram_wr_en   = (state == ST_CLEAR) || (fire && upd_written);
  assign ram_wr_addr = (state == ST_CLEAR) ? clr_addr : idx;
  assign ram_wr_data = (state == ST_CLEAR) ? '0 : ENTRY_W'(upd_entry);
  assign stored      = entry_t'(ram_rd_data);

  dmsc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  dmsc_update u_update (
    .stored    (stored),
    .req       (req),
    .search_age(search_age),
    .result    (upd_entry),
    .written   (upd_written),
    .age_next  (upd_age)
  );

  assign found_tag       = out_entry.tag;
  assign found_score     = out_entry.score;
  assign found_move      = out_entry.move;
  assign found_kind      = out_entry.kind;
  assign found_depth     = out_entry.depth;
  assign found_eval      = out_entry.eval;
  assign found_old_score = out_entry.old_score;
  assign found_age       = out_entry.age;

  `DMSC_CHECK_NEXT(a_xfer_reads, in_xfer, (state == ST_READ) && !in_ready, "request not read")
  `DMSC_CHECK_SAME(a_age_range, 1'b1, search_age != AGE_LIMIT, "search age out of range")
  `DMSC_CHECK_SAME(a_wr_store, ram_wr_en && (state != ST_CLEAR), req.mode == MODE_STORE, "bad write")
  `DMSC_CHECK_SAME(a_out_src, $rose(out_valid), $past(state) == ST_READ, "result without request")

endmodule

// ===== rtl/dmsc_ram.sv =====
module dmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/dmsc_update.sv =====
module dmsc_update (
  input  dmsc_pkg::entry_t stored,
  input  dmsc_pkg::req_t   req,
  input  logic [7:0]       search_age,
  output dmsc_pkg::entry_t result,
  output logic             written,
  output logic [7:0]       age_next
);
  import dmsc_pkg::*;

  logic empty;
  logic replace;
  entry_t fresh;

  assign empty = (stored.tag == 32'd0);

  // Replacement rule for an occupied entry.
  assign replace = (stored.age != search_age)
                || (req.kind == KIND_PV)
                || ((stored.kind != KIND_PV) && (stored.depth <= req.depth))
                || ((stored.tag == req.tag)
                    && ({1'b0, stored.depth} <= {req.depth, 1'b0}));

  assign written = (req.mode == MODE_STORE) && (empty || replace);

  always_comb begin
    fresh.tag       = req.tag;
    fresh.move      = req.move;
    fresh.old_score = req.old_score;
    fresh.eval      = req.eval;
    fresh.score     = req.score;
    fresh.age       = search_age;
    fresh.depth     = req.depth;
    fresh.kind      = req.kind;
  end

  assign result = written ? fresh : stored;

  always_comb begin
    age_next = search_age;
    if (req.mode == MODE_AGE) begin
      age_next = (search_age >= AGE_LAST) ? 8'd0 : search_age + 8'd1;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dmsc_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] KIND_BOUND_1 = 2'd1;
  localparam logic [1:0] KIND_BOUND_2 = 2'd2;
  localparam logic [1:0] KIND_BOUND_3 = 2'd3;

  // The clearing pass after reset covers all 2^INDEX_BITS entries with nothing moving.
  localparam int unsigned STALL_LIMIT = 300000;
  localparam int unsigned HOLD_AT_TRANSFER = 40;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]         mode;
    logic [63:0]        hash;
    logic signed [15:0] score;
    logic [31:0]        move;
    logic [1:0]         kind;
    logic [6:0]         depth;
    logic signed [15:0] eval;
    logic signed [15:0] old_score;
  } request_t;

  typedef struct packed {
    logic   written;
    entry_t entry;
  } readout_t;

  typedef struct {
    request_t req;
    bit       typed;
    readout_t want;
  } directed_row_t;

  typedef struct {
    logic [4:0]  bits;
    int unsigned items;
    int unsigned age_pct;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_WIDTH-1:0] cfg_wr_data = CFG_RESET;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = MODE_LOOKUP;
  logic [63:0] position_hash = '0;
  logic signed [15:0] new_score = '0;
  logic [31:0] new_move = '0;
  logic [1:0] new_kind = KIND_PV;
  logic [6:0] new_depth = '0;
  logic signed [15:0] new_eval = '0;
  logic signed [15:0] new_old_score = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic written;
  logic [31:0] found_tag;
  logic signed [15:0] found_score;
  logic [31:0] found_move;
  logic [1:0] found_kind;
  logic [6:0] found_depth;
  logic signed [15:0] found_eval;
  logic signed [15:0] found_old_score;
  logic [7:0] found_age;

  // Shadow copy of the cache contents and its settings.
  entry_t shadow_table [0:(1 << DMSC_INDEX_BITS) - 1];
  logic [7:0] shadow_age;
  logic [4:0] shadow_index_bits;

  readout_t readouts_due[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;

  phase_t phase_plan [6] = '{
    '{5'd2, 60, 5},
    '{5'd0, 30, 5},
    '{5'd31, 50, 5},
    '{5'd4, 60, 10},
    '{5'd1, 280, 92},
    '{5'd16, 40, 5}
  };

  direct_mapped_search_cache_core #(
    .INDEX_BITS(DMSC_INDEX_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .position_hash(position_hash),
    .new_score(new_score),
    .new_move(new_move),
    .new_kind(new_kind),
    .new_depth(new_depth),
    .new_eval(new_eval),
    .new_old_score(new_old_score),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .written(written),
    .found_tag(found_tag),
    .found_score(found_score),
    .found_move(found_move),
    .found_kind(found_kind),
    .found_depth(found_depth),
    .found_eval(found_eval),
    .found_old_score(found_old_score),
    .found_age(found_age)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Applies one request to the shadow cache and returns the entry it reports.
  function automatic readout_t step_shadow_cache(request_t r);
    int unsigned bits;
    logic [DMSC_INDEX_BITS-1:0] slot;
    logic [31:0] key;
    entry_t held;
    logic take;
    readout_t res;
    bits = (shadow_index_bits > DMSC_INDEX_BITS) ? DMSC_INDEX_BITS : shadow_index_bits;
    slot = r.hash[DMSC_INDEX_BITS-1:0] & DMSC_INDEX_BITS'((1 << bits) - 1);
    key = r.hash[63:32];
    held = shadow_table[slot];
    res.written = 1'b0;
    if (r.mode == MODE_STORE) begin
      // Twice the new depth needs eight bits.
      take = (held.tag == 32'd0) || (held.age != shadow_age) || (r.kind == KIND_PV)
          || (held.kind != KIND_PV && held.depth <= r.depth)
          || (held.tag == key && {1'b0, held.depth} <= {r.depth, 1'b0});
      if (take) begin
        shadow_table[slot] = '{tag: key, move: r.move, old_score: r.old_score,
                               eval: r.eval, score: r.score, age: shadow_age,
                               depth: r.depth, kind: r.kind};
        res.written = 1'b1;
      end
    end else if (r.mode == MODE_AGE) begin
      shadow_age = (shadow_age == AGE_LAST) ? 8'd0 : shadow_age + 8'd1;
    end
    res.entry = shadow_table[slot];
    return res;
  endfunction

  function automatic request_t make_req(logic [1:0] m, logic [63:0] h, int s, int unsigned mv,
                                        logic [1:0] k, int unsigned d, int e, int o);
    request_t r;
    r = '{m, h, s[15:0], mv, k, d[6:0], e[15:0], o[15:0]};
    return r;
  endfunction

  // Tags come mostly from a small pool and indexes from a narrow range so that
  // stores collide and the replacement rule is exercised.
  function automatic request_t random_request(int unsigned age_pct);
    request_t r;
    logic [31:0] tag_pool [4];
    int unsigned roll;
    tag_pool = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h9E37_79B9};
    roll = $urandom_range(0, 99);
    if (roll < age_pct) begin
      r.mode = MODE_AGE;
    end else begin
      roll = $urandom_range(0, 19);
      r.mode = (roll == 0) ? MODE_UNUSED : (roll < 9) ? MODE_LOOKUP : MODE_STORE;
    end
    if ($urandom_range(0, 4) == 0) begin
      r.hash = {$urandom, $urandom};
    end else begin
      r.hash[63:32] = tag_pool[2'($urandom_range(0, 3))];
      r.hash[31:0] = ($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 15);
      if ($urandom_range(0, 1) == 0) r.hash[15:4] = '0;
    end
    r.score = 16'($urandom);
    r.move = $urandom;
    r.kind = 2'($urandom_range(0, 3));
    r.depth = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 12));
    r.eval = 16'($urandom);
    r.old_score = 16'($urandom);
    return r;
  endfunction

  // Offers one request in the current burst and returns at the edge of its transfer.
  task automatic send(request_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode <= r.mode;
    position_hash <= r.hash;
    new_score <= r.score;
    new_move <= r.move;
    new_kind <= r.kind;
    new_depth <= r.depth;
    new_eval <= r.eval;
    new_old_score <= r.old_score;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (readouts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : readout_check
    readout_t want;
    if (!rst && out_valid && out_ready) begin
      if (readouts_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result transfer with none outstanding", $realtime);
      end else begin
        want = readouts_due.pop_front();
        compare_field("written", 64'(want.written), 64'(written));
        compare_field("found_tag", 64'(want.entry.tag), 64'(found_tag));
        compare_field("found_score", 64'(want.entry.score), 64'(found_score));
        compare_field("found_move", 64'(want.entry.move), 64'(found_move));
        compare_field("found_kind", 64'(want.entry.kind), 64'(found_kind));
        compare_field("found_depth", 64'(want.entry.depth), 64'(found_depth));
        compare_field("found_eval", 64'(want.entry.eval), 64'(found_eval));
        compare_field("found_old_score", 64'(want.entry.old_score), 64'(found_old_score));
        compare_field("found_age", 64'(want.entry.age), 64'(found_age));
      end
    end
  end

  // The receiver stalls on rotating masks and holds off once for a long stretch.
  initial begin : receiver
    int unsigned seen;
    int unsigned hold;
    int unsigned steps;
    bit held_once;
    logic [7:0] ready_mask;
    seen = 0;
    hold = 0;
    steps = 0;
    held_once = 1'b0;
    ready_mask = 8'hFF;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) seen++;
      if (!held_once && seen == HOLD_AT_TRANSFER) begin
        held_once = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (steps == 0) begin
          ready_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
          steps = 8 * $urandom_range(1, 4);
        end
        steps--;
        out_ready <= ready_mask[steps[2:0]];
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    directed_row_t directed_rows[$];
    request_t r;
    readout_t predicted;
    entry_t extreme_entry;
    entry_t pv_entry;
    entry_t zero_tag_entry;
    logic [63:0] h1, h2, h3, hz, hy;

    foreach (shadow_table[i]) shadow_table[i] = '0;
    shadow_age = 8'd0;
    shadow_index_bits = CFG_RESET;

    // Three tags on the top entry, plus a zero tag and a real tag on one other entry.
    h1 = 64'hFFFF_FFFF_0000_FFFF;
    h2 = 64'h0000_0001_0000_FFFF;
    h3 = 64'h8000_0000_ABCD_FFFF;
    hz = 64'h0000_0000_0000_1234;
    hy = 64'h5A5A_5A5A_FFFF_1234;
    extreme_entry = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd32768, 16'sd32767, -16'sd32768,
                      8'd0, 7'd127, KIND_BOUND_3};
    pv_entry = '{32'h1, 32'h1234_5678, 16'sd7, -16'sd5, 16'sd100, 8'd0, 7'd10, KIND_PV};
    zero_tag_entry = '{32'h0, 32'h2, 16'sd4, 16'sd3, 16'sd1, 8'd0, 7'd64, KIND_BOUND_1};

    directed_rows.push_back('{make_req(MODE_LOOKUP, 64'h0, 0, 0, KIND_PV, 0, 0, 0),
                              1'b1, '{1'b0, '0}});
    directed_rows.push_back('{make_req(MODE_LOOKUP, '1, 0, 0, KIND_PV, 0, 0, 0),
                              1'b1, '{1'b0, '0}});
    directed_rows.push_back('{make_req(MODE_STORE, h1, -32768, 32'hFFFF_FFFF, KIND_BOUND_3,
                                       127, 32767, -32768), 1'b1, '{1'b1, extreme_entry}});
    // Shallower non-PV store with another tag loses to a deep bound entry.
    directed_rows.push_back('{make_req(MODE_STORE, h2, 32767, 0, KIND_BOUND_1, 0, -32768, 32767),
                              1'b1, '{1'b0, extreme_entry}});
    directed_rows.push_back('{make_req(MODE_STORE, h2, 100, 32'h1234_5678, KIND_PV, 10, -5, 7),
                              1'b1, '{1'b1, pv_entry}});
    // A PV entry of the current age is kept against any other tag's bound store.
    directed_rows.push_back('{make_req(MODE_STORE, h3, 0, 0, KIND_BOUND_2, 127, 0, 0),
                              1'b1, '{1'b0, pv_entry}});
    directed_rows.push_back('{make_req(MODE_STORE, h2, -1, 32'hDEAD_BEEF, KIND_BOUND_2, 5, 1, -1),
                              1'b0, '0});
    directed_rows.push_back('{make_req(MODE_STORE, h2, 2, 3, KIND_BOUND_3, 2, 4, 5), 1'b0, '0});
    directed_rows.push_back('{make_req(MODE_STORE, h3, 6, 7, KIND_BOUND_1, 5, 8, 9), 1'b0, '0});
    directed_rows.push_back('{make_req(MODE_STORE, hz, 1, 2, KIND_BOUND_1, 64, 3, 4),
                              1'b1, '{1'b1, zero_tag_entry}});
    directed_rows.push_back('{make_req(MODE_STORE, hy, 5, 6, KIND_BOUND_3, 0, 7, 8), 1'b0, '0});
    directed_rows.push_back('{make_req(MODE_UNUSED, hy, -9, 32'hA5A5_A5A5, KIND_PV, 99, 9, -9),
                              1'b0, '0});
    directed_rows.push_back('{make_req(MODE_AGE, h1, 11, 12, KIND_BOUND_2, 13, 14, 15),
                              1'b0, '0});
    directed_rows.push_back('{make_req(MODE_STORE, h2, 16, 17, KIND_BOUND_3, 0, 18, 19),
                              1'b0, '0});
    directed_rows.push_back('{make_req(MODE_STORE, h2, 20, 21, KIND_PV, 127, 22, 23), 1'b0, '0});
    // Same tag at depth 64 against a PV entry at depth 127: twice the depth decides.
    directed_rows.push_back('{make_req(MODE_STORE, h2, 24, 25, KIND_BOUND_1, 64, 26, 27),
                              1'b0, '0});
    directed_rows.push_back('{make_req(MODE_STORE, h1, 28, 29, KIND_BOUND_2, 127, 30, 31),
                              1'b0, '0});
    directed_rows.push_back('{make_req(MODE_LOOKUP, 64'h0, 0, 0, KIND_PV, 0, 0, 0), 1'b0, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send(directed_rows[i].req);
      predicted = step_shadow_cache(directed_rows[i].req);
      readouts_due.push_back(directed_rows[i].typed ? directed_rows[i].want : predicted);
    end

    foreach (phase_plan[p]) begin
      drain();
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= phase_plan[p].bits;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      shadow_index_bits = phase_plan[p].bits;
      repeat (phase_plan[p].items) begin
        r = random_request(phase_plan[p].age_pct);
        send(r);
        readouts_due.push_back(step_shadow_cache(r));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && readouts_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dmsc_pkg.sv
rtl/dmsc_ram.sv
rtl/dmsc_update.sv
rtl/direct_mapped_search_cache_core.sv
tb/testbench.sv
